// File: rtl/core/nqm_pkg.sv
package nqm_pkg;

  localparam int PHASE_W  = 32;
  localparam int BASE_W   = 31;
  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 17;
  localparam int NUM_CH   = 2;

  localparam logic [LEN_W-1:0] LEN_RESET = 17'd1024;

  // Pi in Q31 fixed point.
  localparam longint unsigned PI_Q31 = 64'd6746518852;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_LOAD,
    ST_DIV,
    ST_ADV
  } nqm_state_e;

  // Request to the phase error divider.
  typedef struct packed {
    logic                     start;
    logic signed [PHASE_W-1:0] dividend;
    logic [LEN_W-1:0]          divisor;
  } div_req_t;

  // One Taylor term step: t * x^2 in Q31.
  function automatic longint unsigned taylor_sq(longint unsigned t, longint unsigned x);
    longint unsigned p;
    p = (t * x) >> 31;
    p = (p * x) >> 31;
    return p;
  endfunction

  // 32767 * sin(2*pi*r / 2^bits) for r in 0..2^bits/4, rounded.
  function automatic logic [15:0] quarter_sine(longint unsigned r, int bits);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint unsigned v;
    x    = (2 * PI_Q31 * r + (64'd1 << (bits - 1))) >> bits;
    term = x;
    sum  = longint'(x);
    term = taylor_sq(term, x) / 6;   sum = sum - longint'(term);
    term = taylor_sq(term, x) / 20;  sum = sum + longint'(term);
    term = taylor_sq(term, x) / 42;  sum = sum - longint'(term);
    term = taylor_sq(term, x) / 72;  sum = sum + longint'(term);
    term = taylor_sq(term, x) / 110; sum = sum - longint'(term);
    term = taylor_sq(term, x) / 156; sum = sum + longint'(term);
    term = taylor_sq(term, x) / 210; sum = sum - longint'(term);
    term = taylor_sq(term, x) / 272; sum = sum + longint'(term);
    term = taylor_sq(term, x) / 342; sum = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = (longint'(sum) * 32767 + (64'd1 << 30)) >> 31;
    if (v > 32767) begin
      v = 32767;
    end
    return v[15:0];
  endfunction

  // Full-wave table entry k, built from the quarter wave by symmetry.
  function automatic logic [15:0] table_entry(int k, int bits);
    int          quarter;
    int          q;
    int          r;
    logic [15:0] v;
    quarter = 1 << (bits - 2);
    q       = k >> (bits - 2);
    r       = k & (quarter - 1);
    case (q)
      0: v = quarter_sine(longint'(r), bits);
      1: v = quarter_sine(longint'(quarter - r), bits);
      2: v = -quarter_sine(longint'(r), bits);
      default: v = -quarter_sine(longint'(quarter - r), bits);
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/nqm_div.sv
module nqm_div
  import nqm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  div_req_t           req_i,
  output logic               done_o,
  output logic [PHASE_W-1:0] quot_o
);

  logic                 busy_q;
  logic                 fin_q;
  logic                 done_q;
  logic [4:0]           cnt_q;
  logic                 neg_q;
  logic [PHASE_W-1:0]   num_q;
  logic [LEN_W-1:0]     rem_q;
  logic [LEN_W-1:0]     dvs_q;
  logic [PHASE_W-1:0]   quot_q;
  logic [LEN_W:0]       trial;
  logic                 fits;

  // Restoring division, one quotient bit per cycle on the magnitude.
  assign trial = {rem_q, num_q[PHASE_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.dividend[PHASE_W-1];
      num_q <= req_i.dividend[PHASE_W-1] ? -req_i.dividend : req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? LEN_W'(trial - {1'b0, dvs_q}) : trial[LEN_W-1:0];
      num_q <= {num_q[PHASE_W-2:0], fits};
    end else if (fin_q) begin
      quot_q <= neg_q ? -num_q : num_q;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: rtl/core/nqm_lane.sv
module nqm_lane
  import nqm_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic signed [15:0]         cos_i,
  input  logic signed [15:0]         sin_i,
  output logic signed [SAMPLE_W-1:0] inph_o,
  output logic signed [SAMPLE_W-1:0] quad_o
);

  logic signed [31:0] prod_i;
  logic signed [31:0] prod_q;

  // Table entries stay within +-32767, so bit 31 of each product only repeats bit 30.
  assign prod_i = sample_i * cos_i;
  assign prod_q = sample_i * sin_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inph_o <= prod_i[30:15];
      quad_o <= prod_q[30:15];
    end
  end

endmodule

// File: rtl/core/nco_quadrature_mixer_unit.sv
// NCO and quadrature mixer for a digital downconverter.
// Input beats arrive on the s_axis group: tuser flags the first beat of a
// timestamped block, tdata carries the reference phase, the base increment
// and one 16-bit sample per channel. Each accepted beat produces exactly one
// output beat on m_axis holding I and Q for both channels.
// The cfg port loads the block length (divisor of the phase error
// correction) with a single-cycle write enable; write it only while idle.
// A beat passes the registered sine table read, then the lane multipliers,
// whose registers double as the output register.
// Throughput is one beat per cycle while no stall or divide holds the input.
// A block-start beat after the phase has been set closes the input while
// the wrapped phase error is divided by the block length in a bit-serial
// divider (32 steps plus load, sign fix, step update and phase advance).
// Reset clears the phase, the step and the phase-set flag and loads a block
// length of 1024. When the receiver deasserts m_axis_tready while an output
// beat waits, the whole pipeline holds and s_axis_tready drops in the same
// cycle.
module nco_quadrature_mixer_unit
  import nqm_pkg::*;
#(
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [31:0] ref_phase, [62:32] base_increment, [78:63] sample_ch0,
  // [94:79] sample_ch1, [95] zero
  input  logic [95:0]      s_axis_tdata_i,
  // [0] block_start
  input  logic             s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // [15:0] inphase_ch0, [31:16] quadrature_ch0, [47:32] inphase_ch1,
  // [63:48] quadrature_ch1
  output logic [63:0]      m_axis_tdata_o,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i
);

  localparam int TabSize    = 1 << TABLE_ADDR_BITS;
  localparam int QuarterOff = TabSize / 4;

  // Sine table, built at elaboration; cosine reads a quarter cycle ahead.
  logic [15:0] rom_w [TabSize];

  for (genvar k = 0; k < TabSize; k++) begin : g_rom
    assign rom_w[k] = table_entry(k, TABLE_ADDR_BITS);
  end

  nqm_state_e           state_q, state_d;
  logic [PHASE_W-1:0]   acc_q, acc_d;
  logic [PHASE_W-1:0]   step_q, step_d;
  logic                 set_q, set_d;
  logic [PHASE_W-1:0]   err_q, err_d;
  logic [BASE_W-1:0]    base_q, base_d;
  logic [LEN_W-1:0]     len_q;

  logic                 en;
  logic                 in_fire;
  logic [PHASE_W-1:0]   in_ref;
  logic [BASE_W-1:0]    in_base;
  logic [TABLE_ADDR_BITS-1:0] sin_addr;
  logic [TABLE_ADDR_BITS-1:0] cos_addr;

  logic                 v1_q;
  logic                 out_valid_q;
  logic signed [15:0]   sin_q;
  logic signed [15:0]   cos_q;
  logic [SAMPLE_W-1:0]  smp_q [NUM_CH];

  div_req_t             div_req;
  logic                 div_done;
  logic [PHASE_W-1:0]   div_quot;

  assign in_ref  = s_axis_tdata_i[31:0];
  assign in_base = s_axis_tdata_i[62:32];

  // The pipeline advances whenever the output register is free or drained.
  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en && (state_q == ST_RUN);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // The very first block start looks up its own reference phase.
  assign sin_addr = (s_axis_tuser_i && !set_q) ?
                    in_ref[PHASE_W-1 -: TABLE_ADDR_BITS] :
                    acc_q[PHASE_W-1 -: TABLE_ADDR_BITS];
  assign cos_addr = sin_addr + TABLE_ADDR_BITS'(QuarterOff);

  always_comb begin
    state_d          = state_q;
    acc_d            = acc_q;
    step_d           = step_q;
    set_d            = set_q;
    err_d            = err_q;
    base_d           = base_q;
    div_req.start    = 1'b0;
    div_req.dividend = err_q;
    div_req.divisor  = (len_q == '0) ? LEN_W'(1) : len_q;
    case (state_q)
      ST_RUN: begin
        if (in_fire) begin
          if (s_axis_tuser_i) begin
            if (!set_q) begin
              set_d  = 1'b1;
              acc_d  = in_ref + {1'b0, in_base};
              step_d = {1'b0, in_base};
            end else begin
              err_d   = in_ref - acc_q;
              base_d  = in_base;
              state_d = ST_LOAD;
            end
          end else begin
            acc_d = acc_q + step_q;
          end
        end
      end
      ST_LOAD: begin
        div_req.start = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          step_d  = {1'b0, base_q} + div_quot;
          state_d = ST_ADV;
        end
      end
      ST_ADV: begin
        // This frame advances with the corrected step.
        acc_d   = acc_q + step_q;
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      acc_q       <= '0;
      step_q      <= '0;
      set_q       <= 1'b0;
      len_q       <= LEN_RESET;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      step_q  <= step_d;
      set_q   <= set_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (en) begin
        v1_q        <= in_fire;
        out_valid_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    err_q  <= err_d;
    base_q <= base_d;
  end

  // Registered table read, held while the pipeline stalls.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sin_q    <= rom_w[sin_addr];
      cos_q    <= rom_w[cos_addr];
      smp_q[0] <= s_axis_tdata_i[78:63];
      smp_q[1] <= s_axis_tdata_i[94:79];
    end
  end

  nqm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    nqm_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .sample_i (smp_q[c]),
      .cos_i    (cos_q),
      .sin_i    (sin_q),
      .inph_o   (m_axis_tdata_o[32*c +: 16]),
      .quad_o   (m_axis_tdata_o[32*c+16 +: 16])
    );
  end

  assign m_axis_tvalid_o = out_valid_q;

  // A plain frame advances the phase by the current step.
  a_phase_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !s_axis_tuser_i |=> acc_q == $past(acc_q + step_q))
    else $error("phase did not advance by the step");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider result outside the divide state");

  // Once set, the phase stays set until reset.
  a_set_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_q |=> set_q)
    else $error("phase-set flag cleared");

  // A table read that moves forward always lands in the output register.
  a_stage_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && en |=> out_valid_q)
    else $error("beat lost between table read and output");

endmodule
